>>> src/lcm_reduce_unit_defines.svh
// Assertion macros shared by the running least common multiple block.
`ifndef LCM_REDUCE_UNIT_DEFINES_SVH
`define LCM_REDUCE_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define LCMR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("lcm_reduce_unit: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define LCMR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("lcm_reduce_unit: next-cycle check failed");

`endif

>>> src/lcmr_pkg.sv
// Shared widths, constants and controller/datapath interface types.
`default_nettype none
package lcmr_pkg;

    localparam int VALUE_W = 63;
    localparam int CNT_W = $clog2(VALUE_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(VALUE_W - 1);
    localparam logic [VALUE_W-1:0] LCM_MAX = '1;

    typedef struct packed {
        logic load;
        logic gcd_step;
        logic div_init;
        logic div_step;
        logic mul_step;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic trivial;
        logic gcd_eq;
        logic cnt_last;
        logic last;
        logic out_busy;
    } t_status;

endpackage
`default_nettype wire

>>> src/lcmr_ctrl.sv
// Sequencer that steps the gcd, divide and multiply phases of one fold.
`default_nettype none
module lcmr_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    input  wire lcmr_pkg::t_status i_status,
    output lcmr_pkg::t_cmd        o_cmd,
    output logic                  o_ready
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_GCD  = 5'b00010,
        S_DIV  = 5'b00100,
        S_MUL  = 5'b01000,
        S_DONE = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = i_status.trivial ? S_DONE : S_GCD;
                end
            end
            S_GCD: begin
                if (i_status.gcd_eq) begin
                    o_cmd.div_init = 1'b1;
                    n_state        = S_DIV;
                end else begin
                    o_cmd.gcd_step = 1'b1;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.cnt_last) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul_step = 1'b1;
                if (i_status.cnt_last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                // A closing beat has to wait until the output register is free.
                if (!i_status.last || !i_status.out_busy) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule
`default_nettype wire

>>> src/lcmr_dp.sv
// Datapath: accumulator, binary gcd, restoring divider, shift-add multiplier.
`default_nettype none
module lcmr_dp (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire lcmr_pkg::t_cmd                i_cmd,
    input  wire logic [lcmr_pkg::VALUE_W-1:0]  i_value,
    input  wire logic                          i_last,
    input  wire logic                          i_ready,
    output lcmr_pkg::t_status                  o_status,
    output logic                               o_valid,
    output logic [lcmr_pkg::VALUE_W-1:0]       o_lcm,
    output logic                               o_overflow
);

    localparam int W = lcmr_pkg::VALUE_W;

    // Run state.
    logic [W-1:0]               r_acc, n_acc;
    logic                       r_first, n_first;
    logic                       r_ovf_seen, n_ovf_seen;
    // Item being folded.
    logic [W-1:0]               r_x, n_x;
    logic                       r_last, n_last;
    logic [W-1:0]               r_res, n_res;
    // Gcd operands and accumulator with the common power of two removed.
    logic [W-1:0]               r_a, n_a;
    logic [W-1:0]               r_b, n_b;
    logic [W-1:0]               r_sh, n_sh;
    // Divider and multiplier.
    logic [W-1:0]               r_rem, n_rem;
    logic [W-1:0]               r_quo, n_quo;
    logic [W-1:0]               r_div, n_div;
    logic [W-1:0]               r_p, n_p;
    logic                       r_movf, n_movf;
    logic [lcmr_pkg::CNT_W-1:0] r_cnt, n_cnt;
    // Output register.
    logic                       r_out_valid, n_out_valid;
    logic [W-1:0]               r_out_lcm, n_out_lcm;
    logic                       r_out_ovf, n_out_ovf;

    logic [W:0]   div_trial;
    logic         div_ge;
    logic [W:0]   div_diff;
    logic [W+1:0] mul_sum;
    logic [W-1:0] a_minus_b;
    logic [W-1:0] b_minus_a;
    logic         cnt_last;

    assign cnt_last  = (r_cnt == lcmr_pkg::CNT_LAST);
    assign a_minus_b = r_a - r_b;
    assign b_minus_a = r_b - r_a;
    assign div_trial = {r_rem, r_quo[W-1]};
    assign div_ge    = (div_trial >= {1'b0, r_div});
    assign div_diff  = div_trial - {1'b0, r_div};
    assign mul_sum   = {1'b0, r_p, 1'b0} + (r_x[W-1] ? {2'b00, r_quo} : '0);

    always_comb begin
        n_acc       = r_acc;
        n_first     = r_first;
        n_ovf_seen  = r_ovf_seen;
        n_x         = r_x;
        n_last      = r_last;
        n_res       = r_res;
        n_a         = r_a;
        n_b         = r_b;
        n_sh        = r_sh;
        n_rem       = r_rem;
        n_quo       = r_quo;
        n_div       = r_div;
        n_p         = r_p;
        n_movf      = r_movf;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && !i_ready;
        n_out_lcm   = r_out_lcm;
        n_out_ovf   = r_out_ovf;

        if (i_cmd.load) begin
            n_x    = i_value;
            n_last = i_last;
            n_a    = r_acc;
            n_b    = i_value;
            n_sh   = r_acc;
            n_cnt  = '0;
            // Only used when the beat needs no fold: first of a run, or a zero operand.
            n_res  = r_first ? i_value : '0;
        end

        if (i_cmd.gcd_step) begin
            if (!r_a[0] && !r_b[0]) begin
                n_a  = r_a >> 1;
                n_b  = r_b >> 1;
                n_sh = r_sh >> 1;
            end else if (!r_a[0]) begin
                n_a = r_a >> 1;
            end else if (!r_b[0]) begin
                n_b = r_b >> 1;
            end else if (r_a > r_b) begin
                n_a = a_minus_b >> 1;
            end else begin
                n_b = b_minus_a >> 1;
            end
        end

        // The odd part of the gcd divides the accumulator once its shared twos are gone.
        if (i_cmd.div_init) begin
            n_rem  = '0;
            n_quo  = r_sh;
            n_div  = r_a;
            n_p    = '0;
            n_movf = 1'b0;
        end

        if (i_cmd.div_step) begin
            n_rem = div_ge ? div_diff[W-1:0] : div_trial[W-1:0];
            n_quo = {r_quo[W-2:0], div_ge};
        end

        if (i_cmd.mul_step) begin
            n_p    = mul_sum[W-1:0];
            n_movf = r_movf || (mul_sum[W+1:W] != 2'b00);
            n_x    = {r_x[W-2:0], 1'b0};
            if (cnt_last) begin
                n_res      = n_movf ? lcmr_pkg::LCM_MAX : n_p;
                n_ovf_seen = r_ovf_seen || n_movf;
            end
        end

        if (i_cmd.div_step || i_cmd.mul_step) begin
            n_cnt = cnt_last ? '0 : r_cnt + 1'b1;
        end

        if (i_cmd.commit) begin
            if (r_last) begin
                n_out_valid = 1'b1;
                n_out_lcm   = r_res;
                n_out_ovf   = r_ovf_seen;
                n_acc       = '0;
                n_first     = 1'b1;
                n_ovf_seen  = 1'b0;
            end else begin
                n_acc   = r_res;
                n_first = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc       <= '0;
            r_first     <= 1'b1;
            r_ovf_seen  <= 1'b0;
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
        end else begin
            r_acc       <= n_acc;
            r_first     <= n_first;
            r_ovf_seen  <= n_ovf_seen;
            r_out_valid <= n_out_valid;
            r_cnt       <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x       <= n_x;
        r_last    <= n_last;
        r_res     <= n_res;
        r_a       <= n_a;
        r_b       <= n_b;
        r_sh      <= n_sh;
        r_rem     <= n_rem;
        r_quo     <= n_quo;
        r_div     <= n_div;
        r_p       <= n_p;
        r_movf    <= n_movf;
        r_out_lcm <= n_out_lcm;
        r_out_ovf <= n_out_ovf;
    end

    assign o_status.trivial  = r_first || (r_acc == '0) || (i_value == '0);
    assign o_status.gcd_eq   = (r_a == r_b);
    assign o_status.cnt_last = cnt_last;
    assign o_status.last     = r_last;
    assign o_status.out_busy = r_out_valid && !i_ready;

    assign o_valid    = r_out_valid;
    assign o_lcm      = r_out_lcm;
    assign o_overflow = r_out_ovf;

endmodule
`default_nettype wire

>>> src/lcm_reduce_unit.sv
// Running least common multiple over a run of values: top level.
//
// Input channel (i_valid/o_ready) takes one value per beat, i_last marking the
// final value of a run. Output channel (o_valid/i_ready) gives one beat per run,
// carrying the least common multiple and a sticky overflow flag; on overflow
// the multiple saturates at 2^63-1 and folding carries on from there.
// The first value of a run, or any beat where the accumulator or the value is
// zero, skips the fold. Any other beat runs a binary gcd (one subtract-and-halve
// step per cycle), a restoring divide and a shift-add multiply; the gcd loop
// sets the variable part of a beat's time. o_ready is high only between beats.
// The result sits in an output register, so a new run may start while it
// waits; if the receiver still holds off when the next run closes, the block
// stalls in its final cycle until the register is free.
// Synchronous active-low reset empties the output register and starts a new
// run; no clearing pass is needed.
`default_nettype none
`include "lcm_reduce_unit_defines.svh"
module lcm_reduce_unit (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic [lcmr_pkg::VALUE_W-1:0]  i_value,
    input  wire logic                          i_last,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic [lcmr_pkg::VALUE_W-1:0]       o_lcm,
    output logic                               o_overflow
);

    lcmr_pkg::t_cmd    cmd;
    lcmr_pkg::t_status status;

    lcmr_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_status (status),
        .o_cmd    (cmd),
        .o_ready  (o_ready)
    );

    lcmr_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_value    (i_value),
        .i_last     (i_last),
        .i_ready    (i_ready),
        .o_status   (status),
        .o_valid    (o_valid),
        .o_lcm      (o_lcm),
        .o_overflow (o_overflow)
    );

    `LCMR_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_valid && o_ready, !o_ready)
    `LCMR_ASSERT_NOW(a_no_result_overwrite, i_clk, i_rst_n, cmd.commit && status.last, !(o_valid && !i_ready))
    `LCMR_ASSERT_NOW(a_result_from_commit, i_clk, i_rst_n, $rose(o_valid), $past(cmd.commit && status.last))

endmodule
`default_nettype wire

>>> sim/tb_lcm_reduce_unit.sv
// Testbench for the running least common multiple block, with a scoreboard and random runs.
module tb_lcm_reduce_unit;

    typedef struct {
        logic [lcmr_pkg::VALUE_W-1:0] lcm;
        logic                         overflow;
    } t_lcm_result;

    // Tracks the running multiple of the current run and holds the results still owed.
    class t_lcm_scoreboard;
        logic [lcmr_pkg::VALUE_W-1:0] running;
        bit                           awaiting_first;
        bit                           overflow_seen;
        t_lcm_result                  pending_runs[$];
        int                           failures;

        function new();
            running        = '0;
            awaiting_first = 1'b1;
            overflow_seen  = 1'b0;
            failures       = 0;
        endfunction

        function logic [63:0] euclid(logic [63:0] a, logic [63:0] b);
            logic [63:0] r;
            while (b != 64'd0) begin
                r = a % b;
                a = b;
                b = r;
            end
            return a;
        endfunction

        // Divide by the gcd before multiplying, so nothing needs more than 64 bits.
        function logic [lcmr_pkg::VALUE_W-1:0] fold(logic [lcmr_pkg::VALUE_W-1:0] acc,
                                                     logic [lcmr_pkg::VALUE_W-1:0] x);
            logic [63:0] g;
            logic [63:0] q;
            logic [63:0] lim;
            lim = {1'b0, lcmr_pkg::LCM_MAX};
            if (acc == '0 || x == '0) begin
                return '0;
            end
            g = euclid({1'b0, acc}, {1'b0, x});
            q = {1'b0, acc} / g;
            if (q > lim / {1'b0, x}) begin
                overflow_seen = 1'b1;
                return lcmr_pkg::LCM_MAX;
            end
            return lcmr_pkg::VALUE_W'(q * {1'b0, x});
        endfunction

        function void take_value(logic [lcmr_pkg::VALUE_W-1:0] x, logic is_last);
            t_lcm_result res;
            if (awaiting_first) begin
                running        = x;
                awaiting_first = 1'b0;
            end else begin
                running = fold(running, x);
            end
            if (is_last) begin
                res.lcm      = running;
                res.overflow = overflow_seen;
                pending_runs.push_back(res);
                running        = '0;
                awaiting_first = 1'b1;
                overflow_seen  = 1'b0;
            end
        endfunction

        function void check_lcm(logic [lcmr_pkg::VALUE_W-1:0] lcm, logic overflow);
            t_lcm_result want;
            if (pending_runs.size() == 0) begin
                $error("unexpected result beat: lcm %h overflow %b", lcm, overflow);
                failures++;
                return;
            end
            want = pending_runs.pop_front();
            if (lcm !== want.lcm) begin
                $error("lcm: expected %h, got %h", want.lcm, lcm);
                failures++;
            end
            if (overflow !== want.overflow) begin
                $error("overflow: expected %b, got %b", want.overflow, overflow);
                failures++;
            end
        endfunction

        function int outstanding();
            return pending_runs.size();
        endfunction

        function int close();
            if (pending_runs.size() != 0) begin
                $error("%0d results never arrived", pending_runs.size());
                failures += pending_runs.size();
            end
            return failures;
        endfunction
    endclass

    logic                         i_clk = 1'b0;
    logic                         i_rst_n;
    logic                         i_valid;
    logic                         o_ready;
    logic [lcmr_pkg::VALUE_W-1:0] i_value;
    logic                         i_last;
    logic                         o_valid;
    logic                         i_ready;
    logic [lcmr_pkg::VALUE_W-1:0] o_lcm;
    logic                         o_overflow;

    int              idle_pct;
    int              stall_pct;
    bit              hold_req;
    bit              holding;
    t_lcm_scoreboard sb;

    lcm_reduce_unit u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_value    (i_value),
        .i_last     (i_last),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_lcm      (o_lcm),
        .o_overflow (o_overflow)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(negedge i_clk) begin
        i_ready <= !holding && ($urandom_range(99) >= stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            sb.check_lcm(o_lcm, o_overflow);
        end
    end

    // A long hold-off on the result side, so the output register fills and the input stalls.
    initial begin
        wait (hold_req);
        @(posedge i_clk);
        holding = 1'b1;
        repeat (4000) @(posedge i_clk);
        holding = 1'b0;
    end

    initial begin
        #15000000;
        $display("end of test: mismatches");
        $finish;
    end

    // Called at a falling edge; returns at the falling edge after the beat is taken.
    task automatic send_value(input logic [lcmr_pkg::VALUE_W-1:0] v, input logic is_last);
        while ($urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_value <= v;
        i_last  <= is_last;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        sb.take_value(v, is_last);
        @(negedge i_clk);
    endtask

    function automatic logic [lcmr_pkg::VALUE_W-1:0] pick_value();
        logic [63:0] v;
        int          sel;
        int          n;
        int          factors[11] = '{2, 3, 5, 7, 11, 13, 16, 9, 25, 27, 32};
        sel = $urandom_range(39);
        if (sel == 0) begin
            v = '0;
        end else if (sel == 1) begin
            v = {1'b0, lcmr_pkg::LCM_MAX};
        end else if (sel < 8) begin
            v = {$urandom, $urandom};
        end else if (sel < 14) begin
            v = 64'($urandom >> $urandom_range(31));
        end else if (sel < 24) begin
            // Numbers built from small primes share factors, so the gcd does real work.
            v = 64'd1;
            n = $urandom_range(1, 4);
            repeat (n) v = v * factors[$urandom_range(10)];
        end else begin
            v = 64'($urandom_range(1, 64));
        end
        return v[lcmr_pkg::VALUE_W-1:0];
    endfunction

    task automatic send_runs(input int count);
        int sent;
        int len;
        sent = 0;
        while (sent < count) begin
            len = ($urandom_range(9) == 0) ? $urandom_range(8, 14) : $urandom_range(1, 6);
            for (int k = 0; k < len; k++) begin
                send_value(pick_value(), k == len - 1);
            end
            sent += len;
        end
    endtask

    initial begin
        sb        = new();
        i_rst_n   = 1'b0;
        i_valid   = 1'b0;
        i_value   = '0;
        i_last    = 1'b0;
        idle_pct  = 0;
        stall_pct = 0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed runs: field extremes, zero handling, saturation and its aftermath.
        send_value(63'd1, 1'b1);
        send_value(lcmr_pkg::LCM_MAX, 1'b1);
        send_value(63'd4, 1'b0);
        send_value(63'd6, 1'b0);
        send_value(63'd10, 1'b1);
        send_value(63'd0, 1'b0);
        send_value(63'd5, 1'b1);
        send_value(63'd7, 1'b0);
        send_value(63'd0, 1'b0);
        send_value(63'd3, 1'b1);
        send_value(63'd0, 1'b0);
        send_value(63'd0, 1'b1);
        send_value(63'h4000_0000_0000_0000, 1'b0);
        send_value(63'd3, 1'b0);
        send_value(63'd5, 1'b0);
        send_value(63'd7, 1'b1);
        send_value(lcmr_pkg::LCM_MAX, 1'b0);
        send_value(63'd2, 1'b1);
        send_value(63'h5555_5555_5555_5555, 1'b0);
        send_value(63'h2AAA_AAAA_AAAA_AAAA, 1'b1);
        send_value(63'h7FFF_FFFF, 1'b0);
        send_value(63'h1_0000_0000, 1'b1);

        hold_req = 1'b1;
        send_runs(150);
        idle_pct = 52;
        send_runs(150);
        idle_pct  = 0;
        stall_pct = 52;
        send_runs(150);
        idle_pct  = 32;
        stall_pct = 32;
        send_runs(150);

        i_valid   <= 1'b0;
        stall_pct = 0;
        while (sb.outstanding() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);

        if (sb.close() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
